// ===== hw/rtl/ssmr_pkg.sv =====
// Shared types and constants for the smoothed sensor Modbus responder.
package ssmr_pkg;

    localparam int LVL_W      = 18;
    localparam int INT_W      = 10;
    localparam int FRAME_BYTES = 8;
    localparam int CRC_SPAN   = 6;

    localparam logic [LVL_W-1:0] LEVEL_MAX = 18'h3FFFF;
    localparam logic [15:0]      CRC_POLY  = 16'hA001;
    localparam logic [15:0]      CRC_INIT  = 16'hFFFF;
    localparam logic [7:0]       READ_FUNC = 8'h03;
    localparam logic [7:0]       REG_LO_REQ = 8'h00;
    localparam logic [7:0]       CNT_LO_REQ = 8'h01;

    localparam logic [7:0] SLAVE_ADDR_RST = 8'd2;
    localparam logic [8:0] GAIN_RST       = 9'd26;

    localparam logic REG_SLAVE_ADDR = 1'b0;
    localparam logic REG_GAIN       = 1'b1;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_LINK   = 1'b1;

    typedef struct packed {
        logic [7:0]       b0;
        logic [7:0]       b1;
        logic [7:0]       b2;
        logic [7:0]       b3;
        logic [INT_W-1:0] level_int;
    } t_job;

endpackage

// ===== hw/rtl/ssmr_front.sv =====
// Front end: config registers, level smoothing and request frame assembly.
module ssmr_front #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic                   i_cfg_index,
    input  logic [8:0]             i_cfg_data,
    input  logic                   i_accept,
    input  logic                   i_mode,
    input  logic [SAMPLE_BITS-1:0] i_sample_value,
    input  logic [7:0]             i_rx_byte,
    output logic                   o_busy,
    output logic                   o_job_push,
    output ssmr_pkg::t_job         o_job
);
    import ssmr_pkg::*;

    localparam int SW = SAMPLE_BITS + 8;
    localparam int DW = ((SW > LVL_W) ? SW : LVL_W) + 1;
    localparam int PW = DW + 10;
    localparam int NW = DW + 3;

    logic [7:0]       r_slave_addr;
    logic [8:0]       r_gain;
    logic [LVL_W-1:0] r_level;
    logic             r_busy;
    logic [PW-1:0]    r_prod;
    logic [2:0]       r_pos;
    logic [7:0]       r_frame [FRAME_BYTES];

    logic                 is_link;
    logic signed [DW-1:0] diff;
    logic signed [PW-1:0] prod;
    logic signed [DW+1:0] step;
    logic signed [NW-1:0] n_sum;
    logic [LVL_W-1:0]     n_level;
    logic                 match;

    assign is_link = (i_mode == MODE_LINK);

    assign diff = $signed({{(DW-SW){1'b0}}, i_sample_value, 8'b0})
                - $signed({{(DW-LVL_W){1'b0}}, r_level});
    assign prod = $signed({1'b0, r_gain}) * diff;
    assign step = $signed(r_prod[PW-1:8]);
    assign n_sum = $signed({{(NW-LVL_W){1'b0}}, r_level}) + $signed({step[DW+1], step});

    always_comb begin
        if (n_sum < 0) begin
            n_level = '0;
        end else if (n_sum > $signed({{(NW-LVL_W){1'b0}}, LEVEL_MAX})) begin
            n_level = LEVEL_MAX;
        end else begin
            n_level = n_sum[LVL_W-1:0];
        end
    end

    assign match = (r_frame[0] == r_slave_addr) && (r_frame[1] == READ_FUNC)
                && (r_frame[3] == REG_LO_REQ) && (r_frame[5] == CNT_LO_REQ);

    assign o_busy     = r_busy;
    assign o_job_push = i_accept && is_link && (r_pos == 3'd7) && match;
    assign o_job      = '{b0: r_frame[0], b1: r_frame[1], b2: r_frame[2], b3: r_frame[3],
                          level_int: r_level[LVL_W-1:8]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= SLAVE_ADDR_RST;
            r_gain       <= GAIN_RST;
            r_level      <= '0;
            r_busy       <= 1'b0;
            r_pos        <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_SLAVE_ADDR: r_slave_addr <= i_cfg_data[7:0];
                    REG_GAIN:       r_gain       <= i_cfg_data;
                    default: ;
                endcase
            end
            r_busy <= i_accept && !is_link;
            if (r_busy) begin
                r_level <= n_level;
            end
            if (i_accept && is_link) begin
                r_pos <= r_pos + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && !is_link) begin
            r_prod <= prod;
        end
        if (i_accept && is_link) begin
            r_frame[r_pos] <= i_rx_byte;
        end
    end

endmodule

// ===== hw/rtl/ssmr_queue.sv =====
// Two-entry request queue between front and back ends.
module ssmr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ssmr_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output ssmr_pkg::t_job o_job
);
    import ssmr_pkg::*;

    t_job       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ===== hw/rtl/ssmr_back.sv =====
// Back end: bit-serial CRC over the reply head, then byte-wise reply output.
module ssmr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  ssmr_pkg::t_job i_job,
    output logic           o_q_pop,
    output logic           o_empty,
    input  logic           i_pop,
    output logic [7:0]     o_tx_byte,
    output logic           o_last_byte
);
    import ssmr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CRC  = 3'b010,
        S_SEND = 3'b100
    } t_state;

    t_state      r_state;
    t_job        r_job;
    logic [2:0]  r_idx;
    logic [2:0]  r_bit;
    logic [15:0] r_crc;

    logic [7:0]  cur_byte;
    logic [15:0] crc_in;
    logic [15:0] n_crc;

    always_comb begin
        case (r_idx)
            3'd0:    cur_byte = r_job.b0;
            3'd1:    cur_byte = r_job.b1;
            3'd2:    cur_byte = r_job.b2;
            3'd3:    cur_byte = r_job.b3;
            3'd4:    cur_byte = {{(16-INT_W){1'b0}}, r_job.level_int[INT_W-1:8]};
            3'd5:    cur_byte = r_job.level_int[7:0];
            3'd6:    cur_byte = r_crc[7:0];
            default: cur_byte = r_crc[15:8];
        endcase
    end

    assign crc_in = (r_bit == 3'd0) ? (r_crc ^ {8'h00, cur_byte}) : r_crc;
    assign n_crc  = crc_in[0] ? ((crc_in >> 1) ^ CRC_POLY) : (crc_in >> 1);

    assign o_q_pop     = (r_state == S_IDLE) && !i_q_empty;
    assign o_empty     = (r_state != S_SEND);
    assign o_tx_byte   = cur_byte;
    assign o_last_byte = (r_idx == 3'(FRAME_BYTES - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_bit   <= '0;
            r_crc   <= CRC_INIT;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= S_CRC;
                        r_idx   <= '0;
                        r_bit   <= '0;
                        r_crc   <= CRC_INIT;
                    end
                end
                S_CRC: begin
                    r_crc <= n_crc;
                    r_bit <= r_bit + 3'd1;
                    if (r_bit == 3'd7) begin
                        if (r_idx == 3'(CRC_SPAN - 1)) begin
                            r_idx   <= '0;
                            r_state <= S_SEND;
                        end else begin
                            r_idx <= r_idx + 3'd1;
                        end
                    end
                end
                S_SEND: begin
                    if (i_pop) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'(FRAME_BYTES - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_job;
        end
    end

endmodule

// ===== hw/rtl/smoothed_sensor_modbus_responder_unit.sv =====
// Top level of the smoothed sensor Modbus read-holding-register responder.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------
//  input    | push / full            | i_mode, i_sample_value, i_rx_byte
//  result   | empty / pop            | o_tx_byte, o_last_byte
//  config   | i_cfg_wr_en            | i_cfg_index, i_cfg_data
//
// A sample request is handled in a multiply step, then an add and saturate step;
// a link byte is stored as it is accepted. A matching frame queues a reply job;
// the back end leaves idle, runs the bit-serial CRC, then offers 8 bytes, one per pop.
// Reset is synchronous; the frame store holds no reset value.
// full rises while a sample is in flight or the two-entry job queue is full.
module smoothed_sensor_modbus_responder_unit #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic                   i_cfg_index,
    input  logic [8:0]             i_cfg_data,
    input  logic                   push,
    output logic                   full,
    input  logic                   i_mode,
    input  logic [SAMPLE_BITS-1:0] i_sample_value,
    input  logic [7:0]             i_rx_byte,
    output logic                   empty,
    input  logic                   pop,
    output logic [7:0]             o_tx_byte,
    output logic                   o_last_byte
);
    import ssmr_pkg::*;

    logic accept;
    logic front_busy;
    logic job_push;
    t_job front_job;
    logic q_full;
    logic q_empty;
    logic q_pop;
    t_job q_job;

    assign full   = front_busy || q_full;
    assign accept = push && !full;

    ssmr_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_accept      (accept),
        .i_mode        (i_mode),
        .i_sample_value(i_sample_value),
        .i_rx_byte     (i_rx_byte),
        .o_busy        (front_busy),
        .o_job_push    (job_push),
        .o_job         (front_job)
    );

    ssmr_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (job_push),
        .i_job  (front_job),
        .i_pop  (q_pop),
        .o_full (q_full),
        .o_empty(q_empty),
        .o_job  (q_job)
    );

    ssmr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_job      (q_job),
        .o_q_pop    (q_pop),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_tx_byte  (o_tx_byte),
        .o_last_byte(o_last_byte)
    );

endmodule

// ===== dv/tb_smoothed_sensor_modbus_responder_unit.sv =====
// Self-checking testbench: smoothing, request frame filtering and reply bytes with CRC.
module tb_smoothed_sensor_modbus_responder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import ssmr_pkg::*;

    localparam int  SAMPLE_W      = 10;
    localparam int  SETTLE_CYCLES = 64;
    localparam int  CYCLE_LIMIT   = 400000;

    typedef logic [FRAME_BYTES-1:0][7:0] t_frame;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
    } t_reply_byte;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_cfg_wr_en    = 1'b0;
    logic                i_cfg_index    = 1'b0;
    logic [8:0]          i_cfg_data     = '0;
    logic                push           = 1'b0;
    logic                full;
    logic                i_mode         = 1'b0;
    logic [SAMPLE_W-1:0] i_sample_value = '0;
    logic [7:0]          i_rx_byte      = '0;
    logic                empty;
    logic                pop            = 1'b0;
    logic [7:0]          o_tx_byte;
    logic                o_last_byte;

    // predictor state
    logic [LVL_W-1:0] level_q;
    logic [7:0]       addr_q;
    logic [8:0]       gain_q;
    t_frame           rx_frame;
    int               frame_pos;

    t_reply_byte reply_due_q[$];
    t_reply_byte popped_due;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          hold_cycles    = 0;
    int          fail_count     = 0;
    int          items_sent     = 0;
    int          cycle_count    = 0;

    smoothed_sensor_modbus_responder_unit #(
        .SAMPLE_BITS(SAMPLE_W)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .push          (push),
        .full          (full),
        .i_mode        (i_mode),
        .i_sample_value(i_sample_value),
        .i_rx_byte     (i_rx_byte),
        .empty         (empty),
        .pop           (pop),
        .o_tx_byte     (o_tx_byte),
        .o_last_byte   (o_last_byte)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("smoothed_sensor_modbus_responder_unit verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("ERROR %0t: %s: got %02h, want %02h", $time, what, got, want);
        fail_count++;
    endtask

    function automatic logic [15:0] crc16_modbus(input t_frame bytes);
        logic [15:0] crc;
        crc = CRC_INIT;
        for (int k = 0; k < CRC_SPAN; k++) begin
            crc ^= {8'h00, bytes[k]};
            for (int b = 0; b < 8; b++) begin
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
        end
        return crc;
    endfunction

    function automatic void reset_predictor();
        level_q   = '0;
        addr_q    = SLAVE_ADDR_RST;
        gain_q    = GAIN_RST;
        rx_frame  = '0;
        frame_pos = 0;
    endfunction

    function automatic void smooth_level(input logic [SAMPLE_W-1:0] sample);
        int diff;
        int prod;
        int nxt;
        diff = int'(sample) * 256 - int'(level_q);
        prod = int'(gain_q) * diff;
        nxt  = int'(level_q) + (prod >>> 8);
        if (nxt < 0) begin
            nxt = 0;
        end else if (nxt > int'(LEVEL_MAX)) begin
            nxt = int'(LEVEL_MAX);
        end
        level_q = nxt[LVL_W-1:0];
    endfunction

    function automatic void collect_link_byte(input logic [7:0] b);
        logic [INT_W-1:0] whole;
        logic [15:0]      crc;
        t_frame           reply;
        t_reply_byte      rb;
        rx_frame[frame_pos] = b;
        frame_pos = (frame_pos + 1) % FRAME_BYTES;
        if (frame_pos != 0) begin
            return;
        end
        if (rx_frame[0] != addr_q || rx_frame[1] != READ_FUNC ||
            rx_frame[3] != REG_LO_REQ || rx_frame[5] != CNT_LO_REQ) begin
            return;
        end
        whole    = level_q[LVL_W-1:8];
        reply    = rx_frame;
        reply[4] = {6'b0, whole[9:8]};
        reply[5] = whole[7:0];
        crc      = crc16_modbus(reply);
        reply[6] = crc[7:0];
        reply[7] = crc[15:8];
        for (int k = 0; k < FRAME_BYTES; k++) begin
            rb.tx_byte   = reply[k];
            rb.last_byte = (k == FRAME_BYTES - 1);
            reply_due_q.push_back(rb);
        end
    endfunction

    // result side: check each popped byte, then decide next pop
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (reply_due_q.size() == 0) begin
                    report_mismatch("reply byte with no request due", o_tx_byte, 8'h00);
                end else begin
                    popped_due = reply_due_q.pop_front();
                    if (o_tx_byte !== popped_due.tx_byte) begin
                        report_mismatch("tx_byte", o_tx_byte, popped_due.tx_byte);
                    end
                    if (o_last_byte !== popped_due.last_byte) begin
                        report_mismatch("last_byte", {7'b0, o_last_byte},
                                        {7'b0, popped_due.last_byte});
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_item(input logic mode, input logic [SAMPLE_W-1:0] sample,
                             input logic [7:0] link_byte);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push           <= 1'b1;
        i_mode         <= mode;
        i_sample_value <= sample;
        i_rx_byte      <= link_byte;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (mode == MODE_SAMPLE) begin
            smooth_level(sample);
        end else begin
            collect_link_byte(link_byte);
        end
        items_sent++;
    endtask

    task automatic settle_idle();
        push <= 1'b0;
        while (reply_due_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [8:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        if (idx == REG_SLAVE_ADDR) begin
            addr_q = data[7:0];
        end else begin
            gain_q = data;
        end
    endtask

    function automatic t_frame make_request(input logic [7:0] addr);
        t_frame fr;
        for (int k = 0; k < FRAME_BYTES; k++) begin
            fr[k] = 8'($urandom);
        end
        fr[0] = addr;
        fr[1] = READ_FUNC;
        fr[3] = REG_LO_REQ;
        fr[5] = CNT_LO_REQ;
        return fr;
    endfunction

    task automatic send_frame(input t_frame fr, input int unsigned sample_pct);
        for (int k = 0; k < FRAME_BYTES; k++) begin
            if ($urandom_range(99) < sample_pct) begin
                send_item(MODE_SAMPLE, SAMPLE_W'($urandom), 8'($urandom));
            end
            send_item(MODE_LINK, SAMPLE_W'($urandom), fr[k]);
        end
    endtask

    // pad with stray link bytes until the next byte starts a frame
    task automatic align_frame();
        while (frame_pos != 0) begin
            send_item(MODE_LINK, SAMPLE_W'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_level_limits();
        t_frame fr;
        cfg_write(REG_GAIN, 9'd511);
        send_item(MODE_SAMPLE, 10'd1023, 8'h00);
        fr = make_request(addr_q);
        fr[2] = 8'hFF;
        fr[4] = 8'h00;
        fr[6] = 8'hFF;
        fr[7] = 8'h00;
        send_frame(fr, 0);
        send_item(MODE_SAMPLE, 10'd0, 8'hFF);
        send_frame(make_request(addr_q), 0);
        settle_idle();
        cfg_write(REG_GAIN, 9'd0);
        send_item(MODE_SAMPLE, 10'd1023, 8'h00);
        send_frame(make_request(addr_q), 0);
    endtask

    task automatic test_frame_filters();
        t_frame fr;
        settle_idle();
        cfg_write(REG_SLAVE_ADDR, 9'd255);
        cfg_write(REG_GAIN, 9'd256);
        fr = make_request(8'hFF);
        fr[0] = 8'hFE;
        send_frame(fr, 0);
        fr = make_request(8'hFF);
        fr[1] = 8'h04;
        send_frame(fr, 0);
        fr = make_request(8'hFF);
        fr[3] = 8'h01;
        send_frame(fr, 0);
        fr = make_request(8'hFF);
        fr[5] = 8'h00;
        send_frame(fr, 0);
        send_frame(make_request(8'hFF), 0);
        settle_idle();
        cfg_write(REG_SLAVE_ADDR, 9'd0);
        // samples land between the bytes of a matching request
        send_frame(make_request(8'h00), 50);
    endtask

    task automatic test_random_traffic(input int unsigned idle_pct,
                                       input int unsigned stall_pct, input int n);
        t_frame      fr;
        int          start;
        int unsigned r;
        settle_idle();
        r = $urandom_range(9);
        cfg_write(REG_SLAVE_ADDR, (r == 0) ? 9'd0 : (r == 1) ? 9'd255 : 9'($urandom_range(255)));
        r = $urandom_range(99);
        cfg_write(REG_GAIN, (r < 15) ? 9'd0 : (r < 30) ? 9'd256 : (r < 40) ? 9'd511 :
                            9'($urandom_range(1, 255)));
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = items_sent;
        while (items_sent - start < n) begin
            r = $urandom_range(99);
            if (r < 55) begin
                align_frame();
                send_frame(make_request(addr_q), 15);
            end else if (r < 70) begin
                send_item(MODE_SAMPLE, SAMPLE_W'($urandom), 8'($urandom));
            end else if (r < 82) begin
                align_frame();
                fr = make_request(addr_q);
                case ($urandom_range(3))
                    0: fr[0] ^= 8'($urandom_range(1, 255));
                    1: fr[1] ^= 8'($urandom_range(1, 255));
                    2: fr[3] ^= 8'($urandom_range(1, 255));
                    default: fr[5] ^= 8'($urandom_range(1, 255));
                endcase
                send_frame(fr, 15);
            end else begin
                send_item(1'($urandom), SAMPLE_W'($urandom), 8'($urandom));
            end
        end
    endtask

    task automatic test_backpressure();
        settle_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        align_frame();
        hold_cycles = 700;
        repeat (6) send_frame(make_request(addr_q), 0);
        // sender waits for every reply before going on
        settle_idle();
    endtask

    initial begin
        reset_predictor();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_level_limits();
        test_frame_filters();
        test_random_traffic(0, 0, 55);
        test_random_traffic(60, 0, 55);
        test_random_traffic(0, 60, 55);
        test_random_traffic(10, 10, 55);
        test_backpressure();
        settle_idle();
        if (fail_count == 0) begin
            $display("smoothed_sensor_modbus_responder_unit verification clean");
        end else begin
            $display("smoothed_sensor_modbus_responder_unit verification failed");
        end
        $finish;
    end
endmodule
